>>> hw/rtl/qmr_pkg.sv
package qmr_pkg;

    // Number format
    localparam int DATA_WIDTH = 24;
    localparam int FRAC_BITS  = 16;

    // Operands carry one extra bit so that negating the most negative value stays exact
    localparam int OP_W   = DATA_WIDTH + 1;
    localparam int PROD_W = 2 * OP_W;
    localparam int SUM_W  = PROD_W + 2;

    // Terms per product: four components of four products each
    localparam int N_COMP = 4;
    localparam int N_TERM = 16;

    // Component positions
    localparam int CX = 0;
    localparam int CY = 1;
    localparam int CZ = 2;
    localparam int CW = 3;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic signed [OP_W-1:0]       op_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [SUM_W-1:0]      sum_t;

    localparam data_t DATA_MAX = data_t'({1'b0, {(DATA_WIDTH-1){1'b1}}});
    localparam data_t DATA_MIN = data_t'({1'b1, {(DATA_WIDTH-1){1'b0}}});

    // 1.0 in the fixed-point format, held at the largest value when it does not fit
    localparam op_t ONE_OP = (FRAC_BITS < DATA_WIDTH - 1) ?
                             (op_t'(1) <<< FRAC_BITS) : op_t'(DATA_MAX);

    localparam sum_t ROUND_HALF = sum_t'(1) <<< (FRAC_BITS - 1);

    // Hamilton product term table, four terms per output component (x, y, z, w)
    localparam int A_IDX [N_TERM] = '{CW, CX, CY, CZ,  CW, CX, CY, CZ,
                                      CW, CX, CY, CZ,  CW, CX, CY, CZ};
    localparam int B_IDX [N_TERM] = '{CX, CW, CZ, CY,  CY, CZ, CW, CX,
                                      CZ, CY, CX, CW,  CW, CX, CY, CZ};
    // Terms that are subtracted
    localparam logic [N_TERM-1:0] TERM_NEG = 16'b1110_0100_0010_1000;

endpackage

>>> hw/rtl/quaternion_multiply_rotate.sv
// Throughput: one request per cycle while the output is not stalled; the four stages
// (multiply, sum, multiply, sum) each hold one request. A stall at the output holds
// the occupied stages from the output back to the first empty one, while that empty
// stage and the stages before it keep filling.
// Reset (rst_n, asynchronous, active low) clears the stage valid bits only;
// the data registers keep whatever they hold.
module quaternion_multiply_rotate
    import qmr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    input  logic  cmd,
    input  data_t quat_x,
    input  data_t quat_y,
    input  data_t quat_z,
    input  data_t quat_w,
    input  data_t other_x,
    input  data_t other_y,
    input  data_t other_z,
    input  data_t other_w,
    output logic  out_valid,
    input  logic  out_stall,
    output data_t res_x,
    output data_t res_y,
    output data_t res_z,
    output data_t res_w,
    output logic  saturated
);

    // Stage valid bits and advance enables
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    assign adv4 = !v4_reg || !out_stall;
    assign adv3 = !v3_reg || adv4;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign in_stall = !adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    // Stage 1 operands: rotate mode puts 1.0 in the vector's scalar
    op_t a1 [N_COMP];
    op_t b1 [N_COMP];

    always_comb
    begin
        a1[CX] = op_t'(quat_x);
        a1[CY] = op_t'(quat_y);
        a1[CZ] = op_t'(quat_z);
        a1[CW] = op_t'(quat_w);
        b1[CX] = op_t'(other_x);
        b1[CY] = op_t'(other_y);
        b1[CZ] = op_t'(other_z);
        b1[CW] = cmd ? ONE_OP : op_t'(other_w);
    end

    prod_t prod1 [N_TERM];

    qmr_mul_stage u_mul1
    (
        .clk  (clk),
        .en   (adv1),
        .a    (a1),
        .b    (b1),
        .prod (prod1)
    );

    // Side registers of each stage
    logic  cmd1_reg, cmd2_reg, cmd3_reg, cmd4_reg;
    op_t   q1_reg    [N_COMP];
    op_t   conj2_reg [N_COMP];
    data_t t3_reg    [N_COMP];
    data_t t4_reg    [N_COMP];
    logic  sat3_reg, sat4_reg;

    data_t t2 [N_COMP];
    logic  sat2;

    qmr_sum_stage u_sum1
    (
        .clk  (clk),
        .en   (adv2),
        .prod (prod1),
        .res  (t2),
        .sat  (sat2)
    );

    // Second product: first result times the conjugate of q
    op_t a3 [N_COMP];

    always_comb
    begin
        for (int c = 0; c < N_COMP; c++)
        begin
            a3[c] = op_t'(t2[c]);
        end
    end

    prod_t prod3 [N_TERM];

    qmr_mul_stage u_mul2
    (
        .clk  (clk),
        .en   (adv3),
        .a    (a3),
        .b    (conj2_reg),
        .prod (prod3)
    );

    data_t r4 [N_COMP];
    logic  sat4;

    qmr_sum_stage u_sum2
    (
        .clk  (clk),
        .en   (adv4),
        .prod (prod3),
        .res  (r4),
        .sat  (sat4)
    );

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            cmd1_reg <= cmd;
            q1_reg   <= a1;
        end
        if (adv2)
        begin
            cmd2_reg      <= cmd1_reg;
            conj2_reg[CX] <= -q1_reg[CX];
            conj2_reg[CY] <= -q1_reg[CY];
            conj2_reg[CZ] <= -q1_reg[CZ];
            conj2_reg[CW] <= q1_reg[CW];
        end
        if (adv3)
        begin
            cmd3_reg <= cmd2_reg;
            t3_reg   <= t2;
            sat3_reg <= sat2;
        end
        if (adv4)
        begin
            cmd4_reg <= cmd3_reg;
            t4_reg   <= t3_reg;
            sat4_reg <= sat3_reg;
        end
    end

    // Result select: Hamilton product leaves after the first pass
    assign out_valid = v4_reg;
    assign res_x     = cmd4_reg ? r4[CX] : t4_reg[CX];
    assign res_y     = cmd4_reg ? r4[CY] : t4_reg[CY];
    assign res_z     = cmd4_reg ? r4[CZ] : t4_reg[CZ];
    assign res_w     = cmd4_reg ? r4[CW] : t4_reg[CW];
    assign saturated = sat4_reg || (cmd4_reg && sat4);

endmodule

>>> hw/rtl/qmr_mul_stage.sv
// Sixteen partial products of one Hamilton product, registered
module qmr_mul_stage
    import qmr_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  op_t   a [N_COMP],
    input  op_t   b [N_COMP],
    output prod_t prod [N_TERM]
);

    prod_t prod_next [N_TERM];
    prod_t prod_reg  [N_TERM];

    // One multiplier per term, operands widened before the multiply
    always_comb
    begin
        for (int k = 0; k < N_TERM; k++)
        begin
            prod_next[k] = prod_t'(a[A_IDX[k]]) * prod_t'(b[B_IDX[k]]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

>>> hw/rtl/qmr_sum_stage.sv
// Adds the signed terms of each component, rounds to nearest and saturates
module qmr_sum_stage
    import qmr_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  prod_t prod [N_TERM],
    output data_t res [N_COMP],
    output logic  sat
);

    sum_t  acc [N_COMP];
    sum_t  rnd [N_COMP];
    logic  [N_COMP-1:0] ovf;
    data_t res_next [N_COMP];
    data_t res_reg  [N_COMP];
    logic  sat_reg;

    // Exact sum, round half up, clamp on overflow of the top bits
    always_comb
    begin
        for (int c = 0; c < N_COMP; c++)
        begin
            acc[c] = '0;
            for (int t = 0; t < 4; t++)
            begin
                if (TERM_NEG[4*c + t])
                    acc[c] = acc[c] - sum_t'(prod[4*c + t]);
                else
                    acc[c] = acc[c] + sum_t'(prod[4*c + t]);
            end
            rnd[c] = (acc[c] + ROUND_HALF) >>> FRAC_BITS;
            ovf[c] = !((&rnd[c][SUM_W-1:DATA_WIDTH-1]) || (~|rnd[c][SUM_W-1:DATA_WIDTH-1]));
            if (ovf[c])
                res_next[c] = rnd[c][SUM_W-1] ? DATA_MIN : DATA_MAX;
            else
                res_next[c] = rnd[c][DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
            sat_reg <= |ovf;
        end
    end

    assign res = res_reg;
    assign sat = sat_reg;

endmodule

>>> hw/rtl/qmr_checker.sv
// Port-level checks of the quaternion unit
module qmr_checker
    import qmr_pkg::*;
(
    input logic  clk,
    input logic  rst_n,
    input logic  in_valid,
    input logic  in_stall,
    input logic  out_valid,
    input logic  out_stall,
    input data_t res_x,
    input data_t res_y,
    input data_t res_z,
    input data_t res_w,
    input logic  saturated
);

    // A stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

    // A stalled result does not change
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(res_x) && $stable(res_y) && $stable(res_z)
                                   && $stable(res_w) && $stable(saturated))
    else $error("stalled result changed");

    // A free output never holds back requests
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
    else $error("input stalled while output free");

    // With no stall an accepted request comes out at the end of the pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !out_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
        |=> out_valid)
    else $error("result missing after pipeline latency");

endmodule

bind quaternion_multiply_rotate qmr_checker u_qmr_checker (.*);
